// File: rtl/core/pssm_pkg.sv
// Shared types and constants for the motif scanner.
// No dependencies; imported by pssm_hit_out and pssm_multi_matrix_scanner.
package pssm_pkg;

  localparam int ENTRY_W  = 16;  // score entry, signed Q8.8
  localparam int SCORE_W  = 21;  // window score and threshold, signed Q13.8
  localparam int SUM_W    = 23;  // accumulator, wide enough for 63 entries
  localparam int LEN_W    = 6;   // matrix length field
  localparam int MIDX_W   = 3;   // matrix index field
  localparam int COL_W    = 5;   // column field
  localparam int POS_W    = 32;  // sequence position
  localparam int HIT_LIMIT = 8;  // hits reported per base at most
  localparam int NHIT_W   = 4;
  localparam int IN_W     = 56;
  localparam int OUT_W    = 56;

  localparam logic signed [SUM_W-1:0] SUM_HI = 23'sd1048575;
  localparam logic signed [SUM_W-1:0] SUM_LO = -23'sd1048576;

  typedef enum logic [1:0] {
    MODE_SCORE  = 2'd0,
    MODE_PARAM  = 2'd1,
    MODE_SCAN   = 2'd2,
    MODE_NEWSEQ = 2'd3
  } mode_t;

  typedef struct packed {
    logic [LEN_W-1:0]          len;
    logic signed [SCORE_W-1:0] thr;
  } param_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [POS_W-1:0]          position;
    logic [MIDX_W-1:0]         matrix;
  } hit_t;

  typedef struct packed {
    logic push;    // new hit offered
    logic finish;  // scan done, pending hit is the last one
  } hit_req_t;

  typedef struct packed {
    logic push_ready;
    logic finish_done;
  } hit_stat_t;

endpackage

// File: rtl/core/pssm_hit_out.sv
// Hit holding stage and output register for the motif scanner.
// Depends on pssm_pkg (hit_t, hit_req_t, hit_stat_t).
module pssm_hit_out
  import pssm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  hit_req_t         req,
  input  hit_t             hit_in,
  output hit_stat_t        stat,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,  // hit_matrix[2:0], hit_position[34:3], hit_score[55:35]
  output logic             m_tlast
);

  // A hit waits in pend until the next hit or the end of the scan tells
  // whether it is the last one of its base.
  logic pend_v;
  hit_t pend;
  hit_t out_word;
  logic out_last;
  logic out_free;
  logic load_out;

  assign out_free = !m_tvalid || m_tready;
  assign load_out = pend_v && out_free && (req.push || req.finish);

  assign stat.push_ready  = !pend_v || out_free;
  assign stat.finish_done = !pend_v || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (load_out) begin
        m_tvalid <= 1'b1;
        out_word <= pend;
        out_last <= req.finish;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (req.push && stat.push_ready) begin
        pend_v <= 1'b1;
        pend   <= hit_in;
      end else if (req.finish && out_free) begin
        pend_v <= 1'b0;
      end
    end
  end

  assign m_tdata = out_word;
  assign m_tlast = out_last;

endmodule

// File: rtl/core/pssm_multi_matrix_scanner.sv
// Scans a DNA base stream against several position weight matrices.
// Load words are handled in S_IDLE. A scan word visits each matrix in turn and sums the window of
// each enabled matrix whose window fits, stopping after the eighth hit, and waits on output stalls;
// the single read port of the score memory takes one column per cycle. No word is taken mid-scan.
// Sync active-high reset: all matrices disabled, position zero, not ready. Score memory is
// not cleared and must be loaded before use. Depends on pssm_pkg and pssm_hit_out.
module pssm_multi_matrix_scanner
  import pssm_pkg::*;
#(
  parameter int NUM_MATRICES = 8,
  parameter int MAX_LENGTH   = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // matrix_index[2:0], column[7:3], base[9:8], score_value[25:10],
  // matrix_length[31:26], threshold[52:32], zero fill [55:53]
  input  logic [IN_W-1:0]  s_tdata,
  input  logic [1:0]       s_tuser,   // mode[1:0]
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // hit_matrix[2:0], hit_position[34:3], hit_score[55:35]
  output logic             m_tlast    // last hit of this base
);

  localparam int MIW    = (NUM_MATRICES > 1) ? $clog2(NUM_MATRICES) : 1;
  localparam int HAW    = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int ROWS   = NUM_MATRICES * MAX_LENGTH;
  localparam int TBW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SAW    = TBW + 2;
  localparam int SDEPTH = ROWS * 4;

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_CHECK, S_ACCUM, S_EVAL, S_NEXT, S_FLUSH
  } state_t;

  // ---------------------------------------------------------------- input word
  mode_t                     in_mode;
  logic [MIDX_W-1:0]         in_mi;
  logic [COL_W-1:0]          in_col;
  logic [1:0]                in_base;
  logic [ENTRY_W-1:0]        in_score;
  logic [LEN_W-1:0]          in_len;
  logic signed [SCORE_W-1:0] in_thr;
  logic                      accept;

  assign in_mode  = mode_t'(s_tuser);
  assign in_mi    = s_tdata[2:0];
  assign in_col   = s_tdata[7:3];
  assign in_base  = s_tdata[9:8];
  assign in_score = s_tdata[25:10];
  assign in_len   = s_tdata[31:26];
  assign in_thr   = s_tdata[52:32];

  state_t state;
  assign s_tready = (state == S_IDLE) && !rst;
  assign accept   = s_tvalid && s_tready;

  // ------------------------------------------------------------- load decode
  // Loads to a matrix or column beyond the configured size are dropped.
  logic           mi_ok, col_ok;
  logic           score_we, prm_we, hist_we;
  logic [SAW-1:0] score_waddr;
  logic [MIW-1:0] prm_widx;
  param_t         prm_wdata;

  assign mi_ok  = {4'b0, in_mi} < 7'(NUM_MATRICES);
  assign col_ok = {4'b0, in_col} < 9'(MAX_LENGTH);

  assign score_we    = accept && (in_mode == MODE_SCORE) && mi_ok && col_ok;
  assign score_waddr = {TBW'(int'(in_mi) * MAX_LENGTH + int'(in_col)), in_base};
  assign prm_we      = accept && (in_mode == MODE_PARAM) && mi_ok;
  assign prm_widx    = MIW'(in_mi);
  assign hist_we     = accept && (in_mode == MODE_SCAN);

  // Lengths beyond the window are clipped to the window.
  assign prm_wdata.len = ({3'b0, in_len} > 9'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH) : in_len;
  assign prm_wdata.thr = in_thr;

  // ------------------------------------------------------------ sequencer regs
  logic [POS_W-1:0]          pos;       // position of next base in sequence
  logic [HAW-1:0]            wptr;      // pos mod MAX_LENGTH
  logic [NUM_MATRICES-1:0]   prm_vld;   // matrix params written since reset
  logic [POS_W-1:0]          cur_p;     // position of the base being scored
  logic [HAW-1:0]            cur_w;     // its history slot
  logic [MIW-1:0]            m;         // matrix under evaluation
  logic [TBW-1:0]            mat_base;  // m * MAX_LENGTH
  logic [NHIT_W-1:0]         nhits;
  logic [LEN_W-1:0]          cur_len;
  logic signed [SCORE_W-1:0] cur_thr;
  logic [POS_W-1:0]          start_pos;
  logic [HAW-1:0]            hidx;      // history slot of next column to issue
  logic [LEN_W-1:0]          iss_cnt;   // columns issued
  logic [LEN_W-1:0]          acc_cnt;   // columns summed
  logic [LEN_W-1:0]          col1;      // column riding with hist_q
  logic                      v1, v2;    // hist read / score read in flight
  logic signed [SUM_W-1:0]   sum;

  // ------------------------------------------------------------------ memories
  logic [ENTRY_W-1:0] score_mem [SDEPTH];
  logic [ENTRY_W-1:0] score_q;
  logic [SAW-1:0]     score_raddr;
  logic [1:0]         hist_mem [MAX_LENGTH];
  logic [1:0]         hist_q;
  param_t             prm_mem [NUM_MATRICES];
  param_t             prm_q;

  // Row of the column from stage one, base from the history read.
  assign score_raddr = {TBW'(mat_base + TBW'(col1)), hist_q};

  always_ff @(posedge clk) begin
    if (score_we) begin
      score_mem[score_waddr] <= in_score;
    end
    score_q <= score_mem[score_raddr];
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[wptr] <= in_base;
    end
    hist_q <= hist_mem[hidx];
  end

  always_ff @(posedge clk) begin
    if (prm_we) begin
      prm_mem[prm_widx] <= prm_wdata;
    end
    prm_q <= prm_mem[m];
  end

  // ---------------------------------------------------------- datapath terms
  logic [LEN_W-1:0]          len_eff;
  logic                      too_short;
  logic signed [9:0]         sdiff;
  logic [HAW-1:0]            s_idx;
  logic [HAW-1:0]            hidx_inc;
  logic [HAW-1:0]            wptr_inc;
  logic signed [SUM_W-1:0]   entry_ext;
  logic signed [SCORE_W-1:0] sat;
  logic                      hit;
  hit_req_t                  hreq;
  hit_stat_t                 hstat;
  hit_t                      hit_word;

  assign len_eff   = prm_vld[m] ? prm_q.len : '0;
  // Window must lie wholly inside the sequence: len <= cur_p + 1.
  assign too_short = ({26'b0, len_eff} - 32'd1) > cur_p;

  // First window slot: cur_w - (len - 1), wrapped into the history ring.
  always_comb begin
    sdiff = 10'(cur_w) - 10'(len_eff) + 10'sd1;
    if (sdiff[9]) begin
      sdiff = sdiff + 10'(MAX_LENGTH);
    end
  end
  assign s_idx = HAW'(sdiff);

  assign hidx_inc = (hidx == HAW'(MAX_LENGTH - 1)) ? '0 : hidx + 1'b1;
  // Slot restarts at zero when the position wraps, matching pos mod MAX_LENGTH.
  assign wptr_inc = ((pos == '1) || (wptr == HAW'(MAX_LENGTH - 1))) ? '0 : wptr + 1'b1;

  assign entry_ext = {{(SUM_W - ENTRY_W){score_q[ENTRY_W-1]}}, score_q};

  always_comb begin
    if (sum > SUM_HI) begin
      sat = SCORE_W'(SUM_HI);
    end else if (sum < SUM_LO) begin
      sat = SCORE_W'(SUM_LO);
    end else begin
      sat = SCORE_W'(sum);
    end
  end
  assign hit = sat >= cur_thr;

  assign hreq.push         = (state == S_EVAL) && hit;
  assign hreq.finish       = (state == S_FLUSH);
  assign hit_word.matrix   = MIDX_W'(m);
  assign hit_word.position = start_pos;
  assign hit_word.score    = sat;

  // ----------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      pos     <= '0;
      wptr    <= '0;
      prm_vld <= '0;
      v1      <= 1'b0;
      v2      <= 1'b0;
    end else begin
      v1 <= 1'b0;
      v2 <= v1;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (in_mode)
              MODE_SCORE: begin
              end
              MODE_PARAM: begin
                if (mi_ok) begin
                  prm_vld[prm_widx] <= 1'b1;
                end
              end
              MODE_SCAN: begin
                cur_p    <= pos;
                cur_w    <= wptr;
                pos      <= pos + 1'b1;
                wptr     <= wptr_inc;
                m        <= '0;
                mat_base <= '0;
                nhits    <= '0;
                state    <= S_PREP;
              end
              MODE_NEWSEQ: begin
                pos  <= '0;
                wptr <= '0;
              end
            endcase
          end
        end
        S_PREP: begin
          state <= S_CHECK;  // parameter read of matrix m lands
        end
        S_CHECK: begin
          if ((len_eff == '0) || too_short) begin
            state <= S_NEXT;
          end else begin
            cur_len   <= len_eff;
            cur_thr   <= prm_q.thr;
            start_pos <= cur_p - ({26'b0, len_eff} - 32'd1);
            hidx      <= s_idx;
            iss_cnt   <= '0;
            acc_cnt   <= '0;
            sum       <= '0;
            state     <= S_ACCUM;
          end
        end
        S_ACCUM: begin
          // Three-deep chain: history read, score read, accumulate.
          if (iss_cnt < cur_len) begin
            v1      <= 1'b1;
            col1    <= iss_cnt;
            iss_cnt <= iss_cnt + 1'b1;
            hidx    <= hidx_inc;
          end
          if (v2) begin
            sum     <= sum + entry_ext;
            acc_cnt <= acc_cnt + 1'b1;
            if (acc_cnt + 1'b1 == cur_len) begin
              state <= S_EVAL;
            end
          end
        end
        S_EVAL: begin
          if (!hit) begin
            state <= S_NEXT;
          end else if (hstat.push_ready) begin
            nhits <= nhits + 1'b1;
            state <= (nhits == NHIT_W'(HIT_LIMIT - 1)) ? S_FLUSH : S_NEXT;
          end
        end
        S_NEXT: begin
          if (m == MIW'(NUM_MATRICES - 1)) begin
            state <= S_FLUSH;
          end else begin
            m        <= m + 1'b1;
            mat_base <= TBW'(int'(mat_base) + MAX_LENGTH);
            state    <= S_PREP;
          end
        end
        S_FLUSH: begin
          if (hstat.finish_done) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ------------------------------------------------------------- result port
  pssm_hit_out u_hit_out (
    .clk      (clk),
    .rst      (rst),
    .req      (hreq),
    .hit_in   (hit_word),
    .stat     (hstat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// File: verif/pssm_multi_matrix_scanner_tb.sv
// Testbench for pssm_multi_matrix_scanner: loads matrices, streams bases, checks every hit.
// A predictor kept in the testbench works out each hit. Only pssm_pkg and the RTL are used.
module pssm_multi_matrix_scanner_tb;
  import pssm_pkg::*;

  localparam int NMAT            = 8;
  localparam int MAXLEN          = 32;
  localparam int TOTAL_WORDS     = 430;   // words sent over the whole run
  localparam int FILL_BUDGET     = 160;   // score loads spent on filling matrices
  localparam int SHORT_LEN       = 6;     // longest usual matrix length in the random part
  localparam int QUIET_WORDS     = 60;    // tail of the run with no idling on either side
  localparam int SETTLE_CYCLES   = 400;   // settling wait at the end of the run
  localparam int WATCHDOG_CYCLES = 3_000_000;

  // One input word: the mode for s_tuser, then the s_tdata fields from the bottom up.
  typedef struct packed {
    mode_t                     mode;
    logic [MIDX_W-1:0]         midx;
    logic [COL_W-1:0]          col;
    logic [1:0]                base;
    logic signed [ENTRY_W-1:0] score;
    logic [LEN_W-1:0]          len;
    logic signed [SCORE_W-1:0] thr;
  } motif_word_t;

  typedef struct packed {
    hit_t hit;
    logic last;
  } motif_hit_t;

  // Directed row: chk set means the outcome is typed in (at most one hit, from midx).
  typedef struct packed {
    motif_word_t               word;
    logic                      chk;
    logic                      nhit;
    logic [POS_W-1:0]          hpos;
    logic signed [SCORE_W-1:0] hscore;
  } dir_row_t;

  localparam int NDIR = 21;
  localparam dir_row_t DIRECTED [NDIR] = '{
    // out of reset every matrix is off: a base gives nothing
    '{'{MODE_SCAN,   3'd0, 5'd0,  2'd0, 16'sh0000, 6'd0,  21'sh000000}, 1'b1, 1'b0, 32'd0, 21'sh0},
    // matrix 0, one column: extremes of the entry range
    '{'{MODE_SCORE,  3'd0, 5'd0,  2'd0, 16'sh7FFF, 6'd0,  21'sh000000}, 1'b1, 1'b0, 32'd0, 21'sh0},
    '{'{MODE_SCORE,  3'd0, 5'd0,  2'd1, 16'sh8000, 6'd0,  21'sh000000}, 1'b1, 1'b0, 32'd0, 21'sh0},
    '{'{MODE_SCORE,  3'd0, 5'd0,  2'd2, 16'sh0000, 6'd0,  21'sh000000}, 1'b1, 1'b0, 32'd0, 21'sh0},
    '{'{MODE_SCORE,  3'd0, 5'd0,  2'd3, 16'shFFFF, 6'd0,  21'sh000000}, 1'b1, 1'b0, 32'd0, 21'sh0},
    '{'{MODE_PARAM,  3'd0, 5'd0,  2'd0, 16'sh0000, 6'd1,  21'sh000000}, 1'b1, 1'b0, 32'd0, 21'sh0},
    '{'{MODE_SCAN,   3'd0, 5'd0,  2'd0, 16'sh0000, 6'd0,  21'sh000000}, 1'b1, 1'b1, 32'd1,
      21'sh007FFF},
    '{'{MODE_SCAN,   3'd0, 5'd0,  2'd1, 16'sh0000, 6'd0,  21'sh000000}, 1'b1, 1'b0, 32'd0, 21'sh0},
    // score equal to threshold still hits
    '{'{MODE_SCAN,   3'd0, 5'd0,  2'd2, 16'sh0000, 6'd0,  21'sh000000}, 1'b1, 1'b1, 32'd3, 21'sh0},
    '{'{MODE_SCAN,   3'd0, 5'd0,  2'd3, 16'sh0000, 6'd0,  21'sh000000}, 1'b1, 1'b0, 32'd0, 21'sh0},
    // lowest threshold: everything hits
    '{'{MODE_PARAM,  3'd0, 5'd0,  2'd0, 16'sh0000, 6'd1,  21'sh100000}, 1'b1, 1'b0, 32'd0, 21'sh0},
    '{'{MODE_SCAN,   3'd0, 5'd0,  2'd1, 16'sh0000, 6'd0,  21'sh000000}, 1'b1, 1'b1, 32'd5,
      21'sh1F8000},
    // highest threshold: nothing hits
    '{'{MODE_PARAM,  3'd0, 5'd0,  2'd0, 16'sh0000, 6'd1,  21'sh0FFFFF}, 1'b1, 1'b0, 32'd0, 21'sh0},
    '{'{MODE_SCAN,   3'd0, 5'd0,  2'd0, 16'sh0000, 6'd0,  21'sh000000}, 1'b1, 1'b0, 32'd0, 21'sh0},
    // new sequence: position back to zero, tables kept
    '{'{MODE_NEWSEQ, 3'd0, 5'd0,  2'd0, 16'sh0000, 6'd0,  21'sh000000}, 1'b1, 1'b0, 32'd0, 21'sh0},
    // oversized length clamps to 32; window cannot fit after one base, so no read
    '{'{MODE_PARAM,  3'd7, 5'd0,  2'd0, 16'sh0000, 6'd63, 21'sh1FFFFF}, 1'b1, 1'b0, 32'd0, 21'sh0},
    '{'{MODE_SCAN,   3'd0, 5'd0,  2'd3, 16'sh0000, 6'd0,  21'sh000000}, 1'b1, 1'b0, 32'd0, 21'sh0},
    '{'{MODE_PARAM,  3'd7, 5'd0,  2'd0, 16'sh0000, 6'd0,  21'sh000000}, 1'b1, 1'b0, 32'd0, 21'sh0},
    '{'{MODE_PARAM,  3'd0, 5'd0,  2'd0, 16'sh0000, 6'd1,  21'sh1F8000}, 1'b1, 1'b0, 32'd0, 21'sh0},
    '{'{MODE_SCAN,   3'd0, 5'd0,  2'd2, 16'sh0000, 6'd0,  21'sh000000}, 1'b1, 1'b1, 32'd1, 21'sh0},
    // last column of the last matrix
    '{'{MODE_SCORE,  3'd7, 5'd31, 2'd3, 16'sh5A5A, 6'd0,  21'sh000000}, 1'b0, 1'b0, 32'd0, 21'sh0}
  };

  logic              clk;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata  = '0;
  logic [1:0]        s_tuser  = 2'd0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;
  logic              m_tlast;

  pssm_multi_matrix_scanner #(
    .NUM_MATRICES(NMAT),
    .MAX_LENGTH  (MAXLEN)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Predictor state
  logic signed [ENTRY_W-1:0] score_mem [NMAT][MAXLEN][4];
  bit                        loaded    [NMAT][MAXLEN][4];
  logic [LEN_W-1:0]          mat_len   [NMAT];
  logic signed [SCORE_W-1:0] mat_thr   [NMAT];
  logic [1:0]                base_hist [MAXLEN];
  logic [POS_W-1:0]          seq_pos;

  motif_hit_t new_hits[$];      // hits of the word just modeled
  motif_hit_t pending_hits[$];  // hits still owed by the block, oldest first

  bit quiet      = 1'b0;
  bit idle_phase = 1'b1;
  int errors     = 0;
  int words_sent = 0;
  int scans      = 0;
  int score_loads = 0;
  int setups     = 0;
  int restarts   = 0;
  int hits_seen  = 0;
  int max_burst  = 0;
  int fill_words = 0;

  function automatic void reset_model();
    foreach (score_mem[m, c, b]) begin
      score_mem[m][c][b] = '0;
      loaded[m][c][b]    = 1'b0;
    end
    foreach (mat_len[m]) begin
      mat_len[m] = '0;
      mat_thr[m] = '0;
    end
    foreach (base_hist[i]) base_hist[i] = 2'd0;
    seq_pos = '0;
  endfunction

  // Works out the hits one accepted word causes and updates the predictor state.
  function automatic void motif_step(input motif_word_t w);
    logic [POS_W-1:0] p;
    logic [POS_W-1:0] start;
    logic [POS_W:0]   filled;
    int               sum;
    motif_hit_t       h;
    new_hits.delete();
    case (w.mode)
      MODE_SCORE: begin
        score_mem[w.midx][w.col][w.base] = w.score;
        loaded[w.midx][w.col][w.base]    = 1'b1;
        score_loads++;
      end
      MODE_PARAM: begin
        mat_len[w.midx] = (w.len > MAXLEN) ? LEN_W'(MAXLEN) : w.len;
        mat_thr[w.midx] = w.thr;
        setups++;
      end
      MODE_NEWSEQ: begin
        seq_pos = '0;
        foreach (base_hist[i]) base_hist[i] = 2'd0;
        restarts++;
      end
      default: begin
        p      = seq_pos;
        filled = {1'b0, p} + 1'b1;
        base_hist[p % MAXLEN] = w.base;
        seq_pos = p + 1'b1;
        for (int m = 0; m < NMAT; m++) begin
          // window must lie wholly inside the current sequence
          if (mat_len[m] != 0 && mat_len[m] <= filled) begin
            start = p - (mat_len[m] - 1'b1);
            sum   = 0;
            for (int c = 0; c < mat_len[m]; c++)
              sum += score_mem[m][c][base_hist[(start + c) % MAXLEN]];
            if (sum > SUM_HI) sum = SUM_HI;
            if (sum < SUM_LO) sum = SUM_LO;
            if (sum >= mat_thr[m]) begin
              h.hit.matrix   = MIDX_W'(m);
              h.hit.position = start;
              h.hit.score    = SCORE_W'(sum);
              h.last         = 1'b0;
              new_hits.push_back(h);
            end
          end
        end
        if (new_hits.size() != 0) new_hits[new_hits.size() - 1].last = 1'b1;
        if (new_hits.size() > max_burst) max_burst = new_hits.size();
        scans++;
      end
    endcase
  endfunction

  // Sender: optional idle burst, or a full drain of owed hits, before the next word.
  task automatic pace(input bit drain);
    int idle;
    idle = 0;
    if (!quiet && idle_phase && $urandom_range(0, 3) == 0) idle = $urandom_range(1, 11);
    if (drain && idle == 0) idle = 1;
    if (idle != 0) begin
      s_tvalid <= 1'b0;
      repeat (idle) @(posedge clk);
      while (drain && pending_hits.size() != 0) @(posedge clk);
    end
  endtask

  // Returns in the time step in which the word was taken.
  task automatic send_word(input motif_word_t w);
    s_tvalid <= 1'b1;
    s_tuser  <= w.mode;
    s_tdata  <= {3'b000, w.thr, w.len, w.score, w.base, w.col, w.midx};
    do @(posedge clk); while (!s_tready);
    words_sent++;
    idle_phase = ((words_sent / 50) % 4) != 3;
  endtask

  task automatic issue(input motif_word_t w, input bit drain);
    pace(drain);
    send_word(w);
    motif_step(w);
    foreach (new_hits[j]) pending_hits.push_back(new_hits[j]);
  endtask

  function automatic motif_word_t rand_word(input mode_t mode);
    motif_word_t w;
    w.mode  = mode;
    w.midx  = MIDX_W'($urandom_range(0, NMAT - 1));
    w.col   = COL_W'($urandom_range(0, MAXLEN - 1));
    w.base  = 2'($urandom_range(0, 3));
    w.score = ENTRY_W'($urandom);
    w.len   = LEN_W'($urandom);
    w.thr   = SCORE_W'($urandom);
    return w;
  endfunction

  // Entries a matrix of this many columns could read that are still unwritten.
  function automatic int unloaded_count(input logic [MIDX_W-1:0] k, input int cols);
    int n;
    n = 0;
    for (int c = 0; c < cols; c++)
      for (int b = 0; b < 4; b++)
        if (!loaded[k][c][b]) n++;
    return n;
  endfunction

  // Loads every entry a matrix of this many columns could read that is still unwritten.
  task automatic fill_matrix(input logic [MIDX_W-1:0] k, input int cols);
    motif_word_t w;
    for (int c = 0; c < cols; c++)
      for (int b = 0; b < 4; b++)
        if (!loaded[k][c][b]) begin
          w      = rand_word(MODE_SCORE);
          w.midx = k;
          w.col  = COL_W'(c);
          w.base = 2'(b);
          fill_words++;
          issue(w, 1'b0);
        end
  endtask

  // Stimulus: reset, directed table, then random words.
  initial begin
    motif_word_t w;
    motif_hit_t  h;
    int          sel;
    int          cols;
    int          span;
    reset_model();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[r]) begin
      pace(1'b0);
      send_word(DIRECTED[r].word);
      motif_step(DIRECTED[r].word);
      if (DIRECTED[r].chk) begin
        if (DIRECTED[r].nhit) begin
          h.hit.matrix   = DIRECTED[r].word.midx;
          h.hit.position = DIRECTED[r].hpos;
          h.hit.score    = DIRECTED[r].hscore;
          h.last         = 1'b1;
          pending_hits.push_back(h);
        end
      end else begin
        foreach (new_hits[j]) pending_hits.push_back(new_hits[j]);
      end
    end

    // Mostly scan runs over live matrices; the first eight passes set up every matrix.
    for (int i = 0; words_sent < TOTAL_WORDS; i++) begin
      quiet = (words_sent >= TOTAL_WORDS - QUIET_WORDS);
      sel   = (i < NMAT) ? 0 : $urandom_range(0, 99);
      if (sel < 8) begin
        w = rand_word(MODE_PARAM);
        if (i < NMAT) w.midx = MIDX_W'(i);
        case ($urandom_range(0, 9))
          0:       w.len = '0;
          1:       w.len = LEN_W'($urandom_range(MAXLEN + 1, 63));
          2:       w.len = LEN_W'(MAXLEN);
          default: w.len = LEN_W'($urandom_range(1, SHORT_LEN));
        endcase
        cols = (w.len > MAXLEN) ? MAXLEN : int'(w.len);
        // long matrices only while the load budget lasts
        if (fill_words + unloaded_count(w.midx, cols) > FILL_BUDGET) begin
          w.len = LEN_W'($urandom_range(1, 3));
          cols  = int'(w.len);
        end
        // threshold near the likely score spread so hits and misses both come up
        span = 20000 * cols + 1;
        if ($urandom_range(0, 4) != 0)
          w.thr = SCORE_W'(int'($urandom_range(0, 2 * span)) - span);
        fill_matrix(w.midx, cols);
      end else if (sel < 18) begin
        w = rand_word(MODE_SCORE);
      end else if (sel < 21) begin
        w = rand_word(MODE_NEWSEQ);
      end else begin
        w = rand_word(MODE_SCAN);
      end
      issue(w, (i % 100) == 50);
    end

    s_tvalid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d words: %0d bases scanned, %0d score loads,", words_sent, scans,
             score_loads);
    $display("%0d matrix setups, %0d restarts; compared %0d hits, up to %0d from one base.",
             setups, restarts, hits_seen, max_burst);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Receiver: random stall bursts, none in the quiet tail.
  initial begin
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Each hit word taken is matched against the oldest hit still owed.
  always @(posedge clk) begin
    hit_t       got;
    motif_hit_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = hit_t'(m_tdata);
      hits_seen++;
      if (pending_hits.size() == 0) begin
        $error("unexpected hit word: matrix %0d position %0d score %0d",
               got.matrix, got.position, got.score);
        errors++;
      end else begin
        want = pending_hits.pop_front();
        check_field("hit_matrix",   want.hit.matrix,   got.matrix);
        check_field("hit_position", want.hit.position, got.position);
        check_field("hit_score",    longint'(want.hit.score), longint'(got.score));
        check_field("last",         want.last,         m_tlast);
      end
    end
  end

  initial begin
    #(WATCHDOG_CYCLES * 10);
    $error("timeout with %0d hits still owed", pending_hits.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
